### rtl/core/mlp_pkg.sv
// shared types and constants for the monochrome lcd pixel plotter
`timescale 1ns / 1ps

package mlp_pkg;

  // bus command prefixes
  localparam logic [7:0] CMD_PAGE     = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH = 8'h10;
  localparam logic [7:0] CMD_COL_LOW  = 8'h00;
  localparam logic [7:0] LOW_NIBBLE   = 8'h0F;

  // configuration port widths
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND_ON = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_ON = 8'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAGE,
    ST_COL_HI,
    ST_COL_LO,
    ST_DATA
  } mlp_state_e;

  typedef enum logic [1:0] {
    BEAT_PAGE,
    BEAT_COL_HI,
    BEAT_COL_LO,
    BEAT_DATA
  } mlp_beat_e;

  // controller to datapath
  typedef struct packed {
    logic      clr_en;
    logic      capture;
    logic      wr_back;
    logic      out_load;
    mlp_beat_e out_sel;
  } mlp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } mlp_sts_t;

endpackage

### rtl/core/mlp_if.sv
// valid/ready channel interfaces for pixel requests, bus writes and configuration
`timescale 1ns / 1ps

interface mlp_pix_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [6:0] pixel_x;
  logic [5:0] pixel_y;

  modport source (output valid, output action, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input action, input pixel_x, input pixel_y, output ready);
endinterface

interface mlp_bus_if;
  logic       valid;
  logic       ready;
  logic       is_command;
  logic [7:0] bus_byte;
  logic       last_write;

  modport source (output valid, output is_command, output bus_byte, output last_write,
                  input ready);
  modport sink (input valid, input is_command, input bus_byte, input last_write,
                output ready);
endinterface

interface mlp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/mlp_ctrl.sv
// controller state machine: clearing pass, pixel accept and bus beat sequencing
`timescale 1ns / 1ps

module mlp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mlp_pkg::mlp_sts_t sts_i,
  output mlp_pkg::mlp_cmd_t cmd_o
);
  import mlp_pkg::*;

  mlp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PAGE;
      end
      ST_PAGE: begin
        if (sts_i.out_free) state_d = ST_COL_HI;
      end
      ST_COL_HI: begin
        if (sts_i.out_free) state_d = ST_COL_LO;
      end
      ST_COL_LO: begin
        if (sts_i.out_free) state_d = ST_DATA;
      end
      ST_DATA: begin
        if (sts_i.out_free) state_d = in_valid_i ? ST_PAGE : ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.clr_en   = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.wr_back  = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.out_sel  = BEAT_PAGE;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_PAGE: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.wr_back  = sts_i.out_free;
        cmd_o.out_sel  = BEAT_PAGE;
      end
      ST_COL_HI: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_sel  = BEAT_COL_HI;
      end
      ST_COL_LO: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_sel  = BEAT_COL_LO;
      end
      ST_DATA: begin
        // next pixel overlaps the data beat
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_sel  = BEAT_DATA;
        in_ready_o     = sts_i.out_free;
        cmd_o.capture  = sts_i.out_free & in_valid_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/mlp_dpath.sv
// datapath: frame store, pixel registers, config registers and bus output register
`timescale 1ns / 1ps

module mlp_dpath #(
  parameter int unsigned PAGE_COUNT   = 8,
  parameter int unsigned COLUMN_COUNT = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           action_i,
  input  logic [6:0]                     pixel_x_i,
  input  logic [5:0]                     pixel_y_i,
  input  mlp_pkg::mlp_cmd_t              cmd_i,
  output mlp_pkg::mlp_sts_t              sts_o,
  input  logic                           cfg_we_i,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mlp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           bus_ready_i,
  output logic                           bus_valid_o,
  output logic                           is_command_o,
  output logic [7:0]                     bus_byte_o,
  output logic                           last_write_o
);
  import mlp_pkg::*;

  localparam int unsigned DEPTH = PAGE_COUNT * COLUMN_COUNT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned MW    = AW + 9;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  logic [AW-1:0] clr_q, clr_d;
  logic          fg_q, bg_q;
  logic          act_q, in_range_q;
  logic [6:0]    x_q;
  logic [2:0]    page_q, bit_q;
  logic [AW-1:0] addr_q;

  logic          out_valid_q, out_valid_d;
  logic          out_cmd_q, out_cmd_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;

  logic [2:0]    page_in;
  logic [MW-1:0] lin_addr;
  logic [AW-1:0] rd_addr;
  logic          in_range;
  logic          colour;
  logic [7:0]    mask;
  logic [7:0]    new_byte;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // eight rows per page
  assign page_in  = pixel_y_i[5:3];
  assign lin_addr = MW'(page_in) * MW'(COLUMN_COUNT) + MW'(pixel_x_i);
  assign rd_addr  = lin_addr[AW-1:0];
  assign in_range = (5'(page_in) < 5'(PAGE_COUNT)) && (9'(pixel_x_i) < 9'(COLUMN_COUNT));

  assign colour   = act_q ? bg_q : fg_q;
  assign mask     = 8'd1 << bit_q;
  assign new_byte = colour ? (rdata_q | mask) : (rdata_q & ~mask);

  assign mem_we    = cmd_i.clr_en | (cmd_i.wr_back & in_range_q);
  assign mem_waddr = cmd_i.clr_en ? clr_q : addr_q;
  assign mem_wdata = cmd_i.clr_en ? 8'd0 : new_byte;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.capture) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign clr_d = cmd_i.clr_en ? clr_q + AW'(1) : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      fg_q  <= 1'b1;
      bg_q  <= 1'b0;
    end else begin
      clr_q <= clr_d;
      if (cfg_we_i && cfg_index_i == REG_FOREGROUND_ON) fg_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_index_i == REG_BACKGROUND_ON) bg_q <= cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q      <= action_i;
      x_q        <= pixel_x_i;
      page_q     <= page_in;
      bit_q      <= pixel_y_i[2:0];
      addr_q     <= rd_addr;
      in_range_q <= in_range;
    end
  end

  always_comb begin
    out_cmd_d  = out_cmd_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        BEAT_PAGE: begin
          out_cmd_d  = 1'b1;
          out_byte_d = CMD_PAGE | {5'd0, page_q};
          out_last_d = 1'b0;
        end
        BEAT_COL_HI: begin
          out_cmd_d  = 1'b1;
          out_byte_d = CMD_COL_HIGH | {5'd0, x_q[6:4]};
          out_last_d = 1'b0;
        end
        BEAT_COL_LO: begin
          out_cmd_d  = 1'b1;
          out_byte_d = CMD_COL_LOW | (8'(x_q) & LOW_NIBBLE);
          out_last_d = 1'b0;
        end
        BEAT_DATA: begin
          // off-screen pixels leave the store alone and send zero
          out_cmd_d  = 1'b0;
          out_byte_d = in_range_q ? new_byte : 8'd0;
          out_last_d = 1'b1;
        end
        default: begin
          out_cmd_d = out_cmd_q;
        end
      endcase
    end
  end

  assign out_valid_d = cmd_i.out_load | (out_valid_q & ~bus_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cmd_q  <= out_cmd_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.clr_last = (clr_q == AW'(DEPTH - 1));
  assign sts_o.out_free = ~out_valid_q | bus_ready_i;

  assign bus_valid_o  = out_valid_q;
  assign is_command_o = out_cmd_q;
  assign bus_byte_o   = out_byte_q;
  assign last_write_o = out_last_q;

endmodule

### rtl/core/mono_lcd_pixel_plotter.sv
// top level of the monochrome lcd pixel plotter
`timescale 1ns / 1ps

// pixel requests come in on pix_i (action, pixel_x, pixel_y); each one turns
// into four beats on bus_o: page command, column-high command, column-low
// command and the updated data byte, which carries last_write
// cfg_i writes foreground_on (index 0) and background_on (index 1) from bit 0
// of data; other indexes are ignored; cfg_i is always ready, write it only
// while no pixel is in flight
// after reset the frame store is cleared one byte a cycle, one pass over all
// PAGE_COUNT * COLUMN_COUNT bytes; pix_i is not ready until that pass is done,
// config writes are taken throughout
// once a pixel is accepted the controller moves to the page state, which loads
// the first beat into the output register; then one beat a cycle while the
// sink is ready; the next pixel is accepted along with the data beat, and the
// four bus beats share the single output register
// when the sink stalls the output register holds its beat and the sequence
// waits; the store read-modify-write happens once per pixel regardless
module mono_lcd_pixel_plotter #(
  parameter int unsigned PAGE_COUNT   = 8,
  parameter int unsigned COLUMN_COUNT = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlp_pix_if.sink    pix_i,
  mlp_cfg_if.sink    cfg_i,
  mlp_bus_if.source  bus_o
);
  import mlp_pkg::*;

  mlp_cmd_t cmd;
  mlp_sts_t sts;
  logic     in_ready;

  assign pix_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

  mlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlp_dpath #(
    .PAGE_COUNT   (PAGE_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (pix_i.action),
    .pixel_x_i    (pix_i.pixel_x),
    .pixel_y_i    (pix_i.pixel_y),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .bus_ready_i  (bus_o.ready),
    .bus_valid_o  (bus_o.valid),
    .is_command_o (bus_o.is_command),
    .bus_byte_o   (bus_o.bus_byte),
    .last_write_o (bus_o.last_write)
  );

endmodule

### sim/mlp_frame_checker.sv
// frame store predictor and bus beat checker for the lcd pixel plotter bench
`timescale 1ns / 1ps

module mlp_frame_checker #(
  parameter int unsigned PAGE_COUNT   = 8,
  parameter int unsigned COLUMN_COUNT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlp_pix_if          pix_i,
  mlp_cfg_if          cfg_i,
  mlp_bus_if          bus_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  import mlp_pkg::*;

  typedef struct packed {
    logic       is_command;
    logic [7:0] bus_byte;
    logic       last_write;
  } bus_beat_t;

  localparam int unsigned STORE_BYTES = PAGE_COUNT * COLUMN_COUNT;

  logic [7:0] shadow_store [STORE_BYTES];
  logic       fg_on;
  logic       bg_on;
  bus_beat_t  bus_beats_q [$];

  // updates the shadow store and queues the four beats one pixel must cause
  task automatic plot_pixel(input logic action, input logic [6:0] x, input logic [5:0] y);
    logic [7:0]  page_byte;
    logic [7:0]  mask;
    logic [7:0]  pix_byte;
    logic        colour;
    int unsigned addr;
    page_byte = 8'(y >> 3);
    mask      = 8'h01 << y[2:0];
    // clear action picks the background register
    colour    = action ? bg_on : fg_on;
    pix_byte  = 8'h00;
    if (page_byte < PAGE_COUNT && x < COLUMN_COUNT) begin
      addr     = page_byte * COLUMN_COUNT + x;
      pix_byte = colour ? (shadow_store[addr] | mask) : (shadow_store[addr] & ~mask);
      shadow_store[addr] = pix_byte;
    end
    bus_beats_q.push_back('{1'b1, CMD_PAGE | page_byte, 1'b0});
    bus_beats_q.push_back('{1'b1, CMD_COL_HIGH | 8'(x >> 4), 1'b0});
    bus_beats_q.push_back('{1'b1, CMD_COL_LOW | (8'(x) & LOW_NIBBLE), 1'b0});
    bus_beats_q.push_back('{1'b0, pix_byte, 1'b1});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bus_beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < STORE_BYTES; i++) shadow_store[i] = 8'h00;
      fg_on = 1'b1;
      bg_on = 1'b0;
      bus_beats_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_FOREGROUND_ON: fg_on = cfg_i.data[0];
          REG_BACKGROUND_ON: bg_on = cfg_i.data[0];
          default: ;
        endcase
      end
      if (bus_i.valid && bus_i.ready) begin
        if (bus_beats_q.size() == 0) begin
          $error("unexpected bus beat: is_command %0b bus_byte %02h last_write %0b",
                 bus_i.is_command, bus_i.bus_byte, bus_i.last_write);
          errors_o++;
        end else begin
          want = bus_beats_q.pop_front();
          if (bus_i.is_command !== want.is_command) begin
            $error("is_command: expected %0b, got %0b", want.is_command, bus_i.is_command);
            errors_o++;
          end
          if (bus_i.bus_byte !== want.bus_byte) begin
            $error("bus_byte: expected %02h, got %02h", want.bus_byte, bus_i.bus_byte);
            errors_o++;
          end
          if (bus_i.last_write !== want.last_write) begin
            $error("last_write: expected %0b, got %0b", want.last_write, bus_i.last_write);
            errors_o++;
          end
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        plot_pixel(pix_i.action, pix_i.pixel_x, pix_i.pixel_y);
      end
    end
    pending_o = bus_beats_q.size();
  end

endmodule

### sim/tb_mono_lcd_pixel_plotter.sv
// stimulus and verdict for the monochrome lcd pixel plotter
`timescale 1ns / 1ps

module tb_mono_lcd_pixel_plotter;
  import mlp_pkg::*;

  localparam logic ACT_DRAW  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_BACKGROUND_ON + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

  localparam int unsigned PHASES       = 5;
  localparam int unsigned PHASE_PIXELS = 30;
  localparam int unsigned MAX_GAP      = 14;
  localparam int unsigned LIMIT_NS     = 600_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          calm;
  int unsigned beats_pending;
  int unsigned mismatch_count;

  mlp_pix_if pix_ch ();
  mlp_cfg_if cfg_ch ();
  mlp_bus_if bus_ch ();

  mono_lcd_pixel_plotter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_ch),
    .cfg_i  (cfg_ch),
    .bus_o  (bus_ch)
  );

  mlp_frame_checker i_frame_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_ch),
    .cfg_i     (cfg_ch),
    .bus_i     (bus_ch),
    .pending_o (beats_pending),
    .errors_o  (mismatch_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // leaves valid high after the beat so a back-to-back pixel needs no toggle
  task automatic send_pixel(input logic action, input logic [6:0] x, input logic [5:0] y);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_ch.valid   <= 1'b1;
    pix_ch.action  <= action;
    pix_ch.pixel_x <= x;
    pix_ch.pixel_y <= y;
    do @(posedge clk_i); while (!pix_ch.ready);
  endtask

  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    do @(negedge clk_i); while (beats_pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // both colour registers plus a write to an unused index, upper data bits random
  task automatic set_colours(input logic fg, input logic bg);
    write_reg(REG_FOREGROUND_ON, {7'($urandom), fg});
    write_reg(REG_BACKGROUND_ON, {7'($urandom), bg});
    write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
              CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // bus side: random stall before every beat unless calm is set
  initial begin : bus_sink
    int unsigned stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        bus_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      bus_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(bus_ch.valid && bus_ch.ready));
    end
  end

  initial begin : stimulus
    logic [1:0]  fg_set [PHASES];
    logic [1:0]  bg_set [PHASES];
    int unsigned hot_x;
    logic [2:0]  hot_page;
    logic [6:0]  x;
    logic [5:0]  y;
    rst_ni         <= 1'b0;
    pix_ch.valid   <= 1'b0;
    pix_ch.action  <= ACT_DRAW;
    pix_ch.pixel_x <= '0;
    pix_ch.pixel_y <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_FOREGROUND_ON;
    cfg_ch.data    <= '0;
    fg_set = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd2};
    bg_set = '{2'd1, 2'd1, 2'd0, 2'd0, 2'd2};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_colours(1'b1, 1'b0);

    // corners, shared bytes, page and column-nibble boundaries
    send_pixel(ACT_DRAW, 7'd0, 6'd0);
    send_pixel(ACT_DRAW, 7'd127, 6'd63);
    send_pixel(ACT_DRAW, 7'd127, 6'd0);
    send_pixel(ACT_DRAW, 7'd0, 6'd63);
    send_pixel(ACT_DRAW, 7'd0, 6'd7);
    send_pixel(ACT_CLEAR, 7'd0, 6'd0);
    send_pixel(ACT_DRAW, 7'd5, 6'd8);
    send_pixel(ACT_DRAW, 7'd5, 6'd15);
    for (int r = 24; r < 32; r++) send_pixel(ACT_DRAW, 7'd64, 6'(r));
    send_pixel(ACT_CLEAR, 7'd64, 6'd27);
    send_pixel(ACT_CLEAR, 7'd127, 6'd63);
    send_pixel(ACT_DRAW, 7'd15, 6'd40);
    send_pixel(ACT_DRAW, 7'd16, 6'd40);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      calm = (p == 1);
      set_colours(fg_set[p][1] ? 1'($urandom) : fg_set[p][0],
                  bg_set[p][1] ? 1'($urandom) : bg_set[p][0]);
      hot_x    = $urandom_range(0, 124);
      hot_page = 3'($urandom);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        // most pixels land in a few bytes so set and clear build on each other
        if ($urandom_range(0, 9) < 6) begin
          x = 7'(hot_x + $urandom_range(0, 3));
          y = {hot_page, 3'($urandom)};
        end else begin
          x = 7'($urandom);
          y = 6'($urandom);
        end
        send_pixel(1'($urandom), x, y);
        if (p == 2 && n == PHASE_PIXELS / 2) wait_drained();
      end
    end

    wait_drained();
    calm = 1'b0;
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #LIMIT_NS;
    $display("tb: failure");
    $finish;
  end

endmodule
